[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the Morse encoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define MCE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define MCE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mce_pkg.sv]
// ----------------------------------------------------------------------------
// Morse encoder package
// Symbol codes, the code table type and the character lookup function.
// ----------------------------------------------------------------------------
package mce_pkg;

    localparam int CharW   = 8;
    localparam int SymW    = 2;
    localparam int MaxSyms = 7;
    localparam int CntW    = 3;

    localparam logic [SymW-1:0] SYM_DOT   = 2'd0;
    localparam logic [SymW-1:0] SYM_DASH  = 2'd1;
    localparam logic [SymW-1:0] SYM_SPACE = 2'd2;
    localparam logic [SymW-1:0] SYM_RSVD  = 2'd3;

    typedef logic [MaxSyms*SymW-1:0] t_syms;

    // Symbols are left-aligned: the first symbol sent sits in the top digit.
    typedef struct packed {
        logic             valid;
        logic [CntW-1:0]  cnt;
        t_syms            syms;
    } t_load;

    typedef struct packed {
        logic [CntW-1:0] cnt;
        t_syms           syms;
    } t_code;

    // Pattern p holds n symbols, first sent in bit n-1, a one meaning a dash.
    function automatic t_code mk(logic [CntW-1:0] n, logic [MaxSyms-1:0] p);
        t_code c;
        c.cnt  = n;
        c.syms = '1;
        for (int i = 0; i < MaxSyms; i++) begin
            c.syms[(MaxSyms-1-i)*SymW +: SymW] = SYM_SPACE;
            if (CntW'(i) < n) begin
                c.syms[(MaxSyms-1-i)*SymW +: SymW] =
                    p[n - CntW'(1) - CntW'(i)] ? SYM_DASH : SYM_DOT;
            end
        end
        return c;
    endfunction

    function automatic t_code spaces(logic [CntW-1:0] n);
        t_code c;
        c.cnt = n;
        for (int i = 0; i < MaxSyms; i++) begin
            c.syms[i*SymW +: SymW] = SYM_SPACE;
        end
        return c;
    endfunction

    function automatic t_code lookup(logic [CharW-1:0] ch_in);
        logic [CharW-1:0] ch;
        t_code c;
        ch = ch_in;
        if (ch >= 8'h61 && ch <= 8'h7A) begin
            ch = ch - 8'h20;
        end
        unique case (ch)
            8'h41: c = mk(3'd2, 7'b01);
            8'h42: c = mk(3'd4, 7'b1000);
            8'h43: c = mk(3'd4, 7'b1010);
            8'h44: c = mk(3'd3, 7'b100);
            8'h45: c = mk(3'd1, 7'b0);
            8'h46: c = mk(3'd4, 7'b0010);
            8'h47: c = mk(3'd3, 7'b110);
            8'h48: c = mk(3'd4, 7'b0000);
            8'h49: c = mk(3'd2, 7'b00);
            8'h4A: c = mk(3'd4, 7'b0111);
            8'h4B: c = mk(3'd3, 7'b101);
            8'h4C: c = mk(3'd4, 7'b0100);
            8'h4D: c = mk(3'd2, 7'b11);
            8'h4E: c = mk(3'd2, 7'b10);
            8'h4F: c = mk(3'd3, 7'b111);
            8'h50: c = mk(3'd4, 7'b0110);
            8'h51: c = mk(3'd4, 7'b1101);
            8'h52: c = mk(3'd3, 7'b010);
            8'h53: c = mk(3'd3, 7'b000);
            8'h54: c = mk(3'd1, 7'b1);
            8'h55: c = mk(3'd3, 7'b001);
            8'h56: c = mk(3'd4, 7'b0001);
            8'h57: c = mk(3'd3, 7'b011);
            8'h58: c = mk(3'd4, 7'b1001);
            8'h59: c = mk(3'd4, 7'b1011);
            8'h5A: c = mk(3'd4, 7'b1100);
            8'h20: c = spaces(3'd3);
            8'h0A: c = spaces(3'd7);
            8'h30: c = mk(3'd5, 7'b11111);
            8'h31: c = mk(3'd5, 7'b01111);
            8'h32: c = mk(3'd5, 7'b00111);
            8'h33: c = mk(3'd5, 7'b00011);
            8'h34: c = mk(3'd5, 7'b00001);
            8'h35: c = mk(3'd5, 7'b00000);
            8'h36: c = mk(3'd5, 7'b10000);
            8'h37: c = mk(3'd5, 7'b11000);
            8'h38: c = mk(3'd5, 7'b11100);
            8'h39: c = mk(3'd5, 7'b11110);
            8'h2E: c = mk(3'd5, 7'b10101);
            8'h2C: c = mk(3'd6, 7'b110011);
            8'h3F: c = mk(3'd6, 7'b001100);
            8'h27: c = mk(3'd6, 7'b011110);
            8'h21: c = mk(3'd6, 7'b101011);
            8'h2F: c = mk(3'd5, 7'b10010);
            8'h28, 8'h7B, 8'h5B: c = mk(3'd5, 7'b10110);
            8'h29, 8'h7D, 8'h5D: c = mk(3'd6, 7'b101101);
            8'h26: c = mk(3'd5, 7'b01000);
            8'h3A: c = mk(3'd6, 7'b111000);
            8'h3B: c = mk(3'd6, 7'b101010);
            8'h3D: c = mk(3'd5, 7'b10001);
            8'h2B: c = mk(3'd5, 7'b01010);
            8'h2D: c = mk(3'd6, 7'b100001);
            8'h5F: c = mk(3'd6, 7'b001101);
            8'h22: c = mk(3'd6, 7'b010010);
            8'h24: c = mk(3'd7, 7'b0001001);
            8'h40: c = mk(3'd6, 7'b011010);
            default: c = spaces(3'd0);
        endcase
        return c;
    endfunction

endpackage

[rtl/mce_ifs.sv]
// ----------------------------------------------------------------------------
// Morse encoder channel interfaces
// Valid/ready channels for character words and symbol words.
// ----------------------------------------------------------------------------
interface mce_char_if import mce_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CharW-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface mce_sym_if import mce_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [SymW-1:0] symbol;
    logic            last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

[rtl/mce_shifter.sv]
// ----------------------------------------------------------------------------
// Morse symbol shifter
// Sends a loaded symbol run one digit per cycle while the sink is ready, then the closing space.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mce_shifter import mce_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_load         i_load,
    output logic          o_free,
    mce_sym_if.source     o_sym
);

    logic            r_busy;
    logic            n_busy;
    logic [CntW-1:0] r_cnt;
    logic [CntW-1:0] n_cnt;
    t_syms           r_syms;
    t_syms           n_syms;
    logic            w_fire;
    logic            w_done;

    assign w_fire = o_sym.valid && o_sym.ready;
    assign w_done = w_fire && (r_cnt == '0);
    assign o_free = !r_busy || w_done;

    assign o_sym.valid  = r_busy;
    assign o_sym.symbol = (r_cnt == '0) ? SYM_SPACE : r_syms[MaxSyms*SymW-1 -: SymW];
    assign o_sym.last   = (r_cnt == '0);

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_syms = r_syms;
        priority if (i_load.valid) begin
            n_busy = 1'b1;
            n_cnt  = i_load.cnt;
            n_syms = i_load.syms;
        end else if (w_done) begin
            n_busy = 1'b0;
        end else if (w_fire) begin
            n_cnt  = r_cnt - CntW'(1);
            n_syms = {r_syms[(MaxSyms-1)*SymW-1:0], SYM_SPACE};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_syms <= n_syms;
    end

    `MCE_ASSERT(a_load_when_free, i_clk, i_rst_n, i_load.valid |-> o_free, "load while busy")
    `MCE_ASSERT(a_idle_after_last, i_clk, i_rst_n, w_done && !i_load.valid |=> !o_sym.valid, "word after last")
    `MCE_ASSERT(a_cnt_down, i_clk, i_rst_n, r_busy && !i_load.valid |=> r_cnt <= $past(r_cnt), "count rose")
    `MCE_ASSERT(a_sym_code, i_clk, i_rst_n, o_sym.valid |-> o_sym.symbol != SYM_RSVD, "bad symbol")

endmodule

[rtl/morse_character_encoder.sv]
// ----------------------------------------------------------------------------
// Morse character encoder
// Translates character words into runs of dot, dash and space words.
// ----------------------------------------------------------------------------
// The first symbol word is offered in the cycle after a character is taken.
// Throughput: one symbol word per cycle while the sink is ready; a character gives its
// run of at most seven symbols and then the closing space, sent by the symbol shifter.
// A new character is taken in the cycle the previous closing space is taken.
// Reset: synchronous, active low; the shifter empties and no word is pending.
module morse_character_encoder import mce_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mce_char_if.sink   i_char,
    mce_sym_if.source  o_sym
);

    logic  w_free;
    t_code w_code;
    t_load w_load;

    assign w_code       = lookup(i_char.char_code);
    assign i_char.ready = w_free;
    assign w_load.valid = i_char.valid && w_free;
    assign w_load.cnt   = w_code.cnt;
    assign w_load.syms  = w_code.syms;

    mce_shifter u_shifter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .o_free  (w_free),
        .o_sym   (o_sym)
    );

endmodule

[test/tb_morse_character_encoder.sv]
// ----------------------------------------------------------------------------
// Morse character encoder testbench
// Sends character words through the valid/ready input channel and checks
// every symbol word against a predictor that expands each character into its
// dot, dash and space run. Covers corner characters, characters picked from the
// code table, random bytes, random idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_morse_character_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import mce_pkg::*;

    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          DRAIN_CYCLES   = 24;
    localparam int          HOLD_CYCLES    = 160;
    localparam int          RANDOM_CHARS   = 105;
    localparam int          HOLD_CHARS     = 24;
    localparam int unsigned CODE_NONE      = 32'd0;
    localparam int unsigned CODE_BLANK     = 32'hFFFF_FFFE;
    localparam int unsigned CODE_NEWLINE   = 32'hFFFF_FFFD;
    localparam int          BLANK_SPACES   = 3;
    localparam int          NEWLINE_SPACES = 7;
    localparam int unsigned DIGIT_DOT      = 1;
    localparam int unsigned DIGIT_DASH     = 3;
    localparam logic [CharW-1:0] CH_NEWLINE = 8'h0A;

    typedef struct packed {
        logic [SymW-1:0] symbol;
        logic            last;
    } t_sym_word;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mce_char_if char_if ();
    mce_sym_if  sym_if ();

    morse_character_encoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_if),
        .o_sym   (sym_if)
    );

    t_sym_word run_expected[$];
    int        src_idle_pct   = 0;
    int        sink_stall_pct = 0;
    int        mismatches     = 0;
    int        chars_sent     = 0;
    int        syms_checked   = 0;
    int        cycle_count    = 0;
    bit        hold_req       = 1'b0;
    logic      hold_active    = 1'b0;
    string     table_chars =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789.,?'!/({[)}]&:;=+-_\"$@ \n";

    always #5ns i_clk = ~i_clk;

    // Each code is a decimal number read from its lowest digit up: 1 is a dot, 3 a dash.
    function automatic int unsigned morse_code_of(logic [CharW-1:0] ch_in);
        logic [CharW-1:0] ch;
        ch = ch_in;
        if (ch >= "a" && ch <= "z") begin
            ch = ch - 8'h20;
        end
        case (ch)
            "A": return 31;       "B": return 1113;     "C": return 1313;
            "D": return 113;      "E": return 1;        "F": return 1311;
            "G": return 133;      "H": return 1111;     "I": return 11;
            "J": return 3331;     "K": return 313;      "L": return 1131;
            "M": return 33;       "N": return 13;       "O": return 333;
            "P": return 1331;     "Q": return 3133;     "R": return 131;
            "S": return 111;      "T": return 3;        "U": return 311;
            "V": return 3111;     "W": return 331;      "X": return 3113;
            "Y": return 3313;     "Z": return 1133;
            " ": return CODE_BLANK;
            CH_NEWLINE: return CODE_NEWLINE;
            "0": return 33333;    "1": return 33331;    "2": return 33311;
            "3": return 33111;    "4": return 31111;    "5": return 11111;
            "6": return 11113;    "7": return 11133;    "8": return 11333;
            "9": return 13333;
            ".": return 31313;    ",": return 331133;   8'h3F: return 113311;
            8'h27: return 133331; "!": return 331313;   "/": return 13113;
            "(", "{", "[": return 13313;
            ")", "}", "]": return 313313;
            "&": return 11131;    ":": return 111333;   ";": return 131313;
            "=": return 31113;    "+": return 13131;    "-": return 311113;
            "_": return 313311;   8'h22: return 131131; "$": return 3113111;
            "@": return 131331;
            default: return CODE_NONE;
        endcase
    endfunction

    function automatic void queue_morse_run(logic [CharW-1:0] ch);
        int unsigned     code;
        int unsigned     digit;
        int              n_spaces;
        int              k;
        t_sym_word       w;
        code     = morse_code_of(ch);
        n_spaces = 0;
        k        = 0;
        w.last   = 1'b0;
        if (code == CODE_BLANK) begin
            n_spaces = BLANK_SPACES;
        end else if (code == CODE_NEWLINE) begin
            n_spaces = NEWLINE_SPACES;
        end
        if (n_spaces != 0) begin
            w.symbol = SYM_SPACE;
            repeat (n_spaces) run_expected.push_back(w);
        end else begin
            while (code != 0 && k < MaxSyms) begin
                digit    = code % 10;
                w.symbol = (digit == DIGIT_DOT)  ? SYM_DOT :
                           (digit == DIGIT_DASH) ? SYM_DASH : SYM_SPACE;
                run_expected.push_back(w);
                code = code / 10;
                k++;
            end
        end
        w.symbol = SYM_SPACE;
        w.last   = 1'b1;
        run_expected.push_back(w);
    endfunction

    function automatic logic [CharW-1:0] pick_char();
        if ($urandom_range(99) < 75) begin
            return table_chars[$urandom_range(table_chars.len() - 1)];
        end
        return CharW'($urandom_range(255));
    endfunction

    // Valid stays high from one word to the next unless an idle gap is drawn.
    task automatic send_char(input logic [CharW-1:0] ch);
        bit taken;
        while ($urandom_range(99) < src_idle_pct) begin
            char_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        char_if.valid     <= 1'b1;
        char_if.char_code <= ch;
        do begin
            @(negedge i_clk);
            taken = char_if.ready;
            if (taken) begin
                queue_morse_run(ch);
            end
            @(posedge i_clk);
        end while (!taken);
        chars_sent++;
    endtask

    task automatic test_corner_chars();
        logic [CharW-1:0] corner_chars [25] = '{
            8'h00, 8'hFF, 8'h80, 8'h7F, " ", CH_NEWLINE, "$", "E", "T", "A",
            "Z", "a", "z", 8'h60, "{", "0", "9", "(", "[", ")",
            "]", "}", 8'h3F, 8'h27, 8'h22
        };
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        foreach (corner_chars[i]) begin
            send_char(corner_chars[i]);
        end
    endtask

    task automatic test_random_chars(input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        repeat (RANDOM_CHARS) send_char(pick_char());
    endtask

    task automatic test_output_hold_off();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req       = 1'b1;
        repeat (HOLD_CHARS) send_char(pick_char());
    endtask

    task automatic finish_run();
        char_if.valid <= 1'b0;
        sink_stall_pct = 0;
        while (run_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (run_expected.size() != 0) begin
            $display("%0t: %0d expected symbol words never arrived",
                     $time, run_expected.size());
            mismatches++;
        end
        $display("Sent %0d characters (corners, table and random bytes, idling, hold-off).",
                 chars_sent);
        $display("Checked %0d symbol words, %0d mismatches.", syms_checked, mismatches);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_active) begin
            sym_if.ready <= 1'b0;
        end else begin
            sym_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always begin
        wait (hold_req);
        @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
        hold_req = 1'b0;
    end

    always @(negedge i_clk) begin
        t_sym_word want;
        if (i_rst_n && sym_if.valid && sym_if.ready) begin
            syms_checked++;
            if (run_expected.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual symbol %0d last %0b",
                         $time, sym_if.symbol, sym_if.last);
                mismatches++;
            end else begin
                want = run_expected.pop_front();
                if (sym_if.symbol !== want.symbol) begin
                    $display("%0t: symbol mismatch, expected %0d, actual %0d",
                             $time, want.symbol, sym_if.symbol);
                    mismatches++;
                end
                if (sym_if.last !== want.last) begin
                    $display("%0t: last mismatch, expected %0b, actual %0b",
                             $time, want.last, sym_if.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        char_if.valid     = 1'b0;
        char_if.char_code = '0;
        sym_if.ready      = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_chars();
        test_random_chars(0, 0);
        test_random_chars(54, 0);
        test_random_chars(0, 54);
        test_random_chars(6, 6);
        test_output_hold_off();
        finish_run();
    end

endmodule
